### rtl/core/iphash_pkg.sv
// iphash_pkg: shared types and constants for the IPv4 hash table core.
// Used by iphash_front, iphash_back and the top level; has no dependencies.
package iphash_pkg;

  localparam int KEY_W   = 32;
  localparam int NODE_W  = 7;
  localparam int REQ_W   = 2;
  localparam int EPOCH_W = 8;
  localparam int Q_DEPTH = 2;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  localparam logic [KEY_W-1:0]   HASH_MULT = 32'h045D9F3B;
  localparam logic [EPOCH_W-1:0] EPOCH_CLR = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_1ST = 8'd1;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [KEY_W-1:0]  ip_address;
    logic [NODE_W-1:0] node_index;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [NODE_W-1:0] node_result;
    logic              table_full;
  } out_item_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

### rtl/core/iphash_fifo.sv
// iphash_fifo: short register queue between the hash front end and the probe engine.
// Depends on nothing beyond its parameters.
module iphash_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_P = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_C = CW'(DEPTH);

  logic [W-1:0]  store_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != FULL_C);
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = store_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_P) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_P) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/core/iphash_front.sv
// iphash_front: accepts request transactions and computes the start slot hash.
// Depends on iphash_pkg; feeds iphash_fifo.
module iphash_front #(
  parameter int SLOTS = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  iphash_pkg::in_item_t       in_data,
  input  iphash_pkg::back_status_t   status,
  output logic                       push_valid,
  input  logic                       push_ready,
  output logic [$bits(iphash_pkg::in_item_t)+$clog2(SLOTS)-1:0] push_data
);
  import iphash_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int RW = AW + 1;
  localparam bit POW2 = ((SLOTS & (SLOTS - 1)) == 0);
  localparam logic [RW-1:0] SLOTS_R = RW'(SLOTS);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_MUL  = 3'd1;
  localparam logic [2:0] F_FOLD = 3'd2;
  localparam logic [2:0] F_MOD  = 3'd3;
  localparam logic [2:0] F_PUSH = 3'd4;

  logic [2:0]       state_r, state_nxt;
  in_item_t         item_r;
  logic [KEY_W-1:0] prod_r;
  logic [KEY_W-1:0] sh_r, sh_nxt;
  logic [AW-1:0]    rem_r, rem_nxt;
  logic [2:0]       dig_r, dig_nxt;
  logic [KEY_W-1:0] xkey, fold;
  logic [AW-1:0]    rem_step;
  logic [AW-1:0]    slot;
  logic             accept;

  assign in_ready = (state_r == F_IDLE) && !status.clearing;
  assign accept   = in_valid && in_ready;
  assign xkey     = item_r.ip_address ^ {16'b0, item_r.ip_address[31:16]};
  assign fold     = prod_r ^ {16'b0, prod_r[31:16]};
  assign slot     = POW2 ? fold[AW-1:0] : rem_r;
  assign push_data = {item_r, slot};
  assign push_valid = ((state_r == F_FOLD) && POW2) || (state_r == F_PUSH);

  always_comb begin
    logic [RW-1:0] t;
    logic [AW-1:0] r;
    r = rem_r;
    t = '0;
    for (int i = 0; i < 4; i++) begin
      t = {r, sh_r[KEY_W-1-i]};
      if (t >= SLOTS_R) begin
        t = t - SLOTS_R;
      end
      r = t[AW-1:0];
    end
    rem_step = r;
  end

  always_comb begin
    state_nxt = state_r;
    sh_nxt    = sh_r;
    rem_nxt   = rem_r;
    dig_nxt   = dig_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = F_MUL;
        end
      end
      F_MUL: begin
        state_nxt = F_FOLD;
      end
      F_FOLD: begin
        if (POW2) begin
          if (push_ready) begin
            state_nxt = F_IDLE;
          end
        end else begin
          sh_nxt    = fold;
          rem_nxt   = '0;
          dig_nxt   = '0;
          state_nxt = F_MOD;
        end
      end
      F_MOD: begin
        rem_nxt = rem_step;
        sh_nxt  = sh_r << 4;
        dig_nxt = dig_r + 1'b1;
        if (dig_r == 3'd7) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (push_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (state_r == F_MUL) begin
      prod_r <= xkey * HASH_MULT;
    end
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    dig_r <= dig_nxt;
  end

endmodule

### rtl/core/iphash_back.sv
// iphash_back: probe engine with the slot memory, epoch-tagged occupancy and result register.
// Depends on iphash_pkg; drains iphash_fifo.
module iphash_back #(
  parameter int SLOTS = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     pop_valid,
  output logic                     pop_ready,
  input  logic [$bits(iphash_pkg::in_item_t)+$clog2(SLOTS)-1:0] pop_data,
  output iphash_pkg::back_status_t status,
  output logic                     out_valid,
  input  logic                     out_ready,
  output iphash_pkg::out_item_t    out_data
);
  import iphash_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int MW = EPOCH_W + KEY_W + NODE_W;
  localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

  localparam logic [1:0] B_INIT  = 2'd0;
  localparam logic [1:0] B_IDLE  = 2'd1;
  localparam logic [1:0] B_PROBE = 2'd2;

  logic [MW-1:0] slot_mem [SLOTS];

  logic [1:0]         state_r, state_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic [AW-1:0]      cnt_r, cnt_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [REQ_W-1:0]   req_r;
  logic [KEY_W-1:0]   key_r;
  logic [NODE_W-1:0]  node_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  in_item_t           q_item;
  logic [AW-1:0]      q_slot;
  logic [AW-1:0]      next_addr;
  logic               rd_en, wr_en, load_req;
  logic [AW-1:0]      rd_addr;
  logic [MW-1:0]      wr_data, rd_q;
  logic               hit_valid, key_match;
  logic               slot_free, out_load;
  out_item_t          out_res;

  assign q_item    = in_item_t'(pop_data[$bits(pop_data)-1:AW]);
  assign q_slot    = pop_data[AW-1:0];
  assign next_addr = (addr_r == LAST) ? '0 : addr_r + 1'b1;
  assign hit_valid = (rd_q[MW-1 -: EPOCH_W] == epoch_r);
  assign key_match = (rd_q[NODE_W +: KEY_W] == key_r);
  assign slot_free = !out_valid_r || out_ready;
  assign status.clearing = (state_r == B_INIT);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    cnt_nxt   = cnt_r;
    epoch_nxt = epoch_r;
    rd_en     = 1'b0;
    rd_addr   = next_addr;
    wr_en     = 1'b0;
    wr_data   = {epoch_r, key_r, node_r};
    pop_ready = 1'b0;
    load_req  = 1'b0;
    out_load  = 1'b0;
    out_res   = '0;
    unique case (state_r)
      B_INIT: begin
        wr_en    = 1'b1;
        wr_data  = {EPOCH_CLR, {(KEY_W + NODE_W){1'b0}}};
        addr_nxt = next_addr;
        if (addr_r == LAST) begin
          epoch_nxt = EPOCH_1ST;
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (pop_valid && slot_free) begin
          pop_ready = 1'b1;
          unique case (q_item.req_type) inside
            REQ_INSERT, REQ_LOOKUP: begin
              rd_en     = 1'b1;
              rd_addr   = q_slot;
              addr_nxt  = q_slot;
              cnt_nxt   = '0;
              load_req  = 1'b1;
              state_nxt = B_PROBE;
            end
            REQ_CLEAR: begin
              out_load = 1'b1;
              if (epoch_r == EPOCH_MAX) begin
                addr_nxt  = '0;
                state_nxt = B_INIT;
              end else begin
                epoch_nxt = epoch_r + 1'b1;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      B_PROBE: begin
        if (!hit_valid) begin
          out_load  = 1'b1;
          state_nxt = B_IDLE;
          if (req_r == REQ_INSERT) begin
            wr_en         = 1'b1;
            out_res.found = 1'b1;
          end
        end else if ((req_r == REQ_LOOKUP) && key_match) begin
          out_load            = 1'b1;
          out_res.found       = 1'b1;
          out_res.node_result = rd_q[NODE_W-1:0];
          state_nxt           = B_IDLE;
        end else if (cnt_r == LAST) begin
          out_load           = 1'b1;
          out_res.table_full = 1'b1;
          state_nxt          = B_IDLE;
        end else begin
          rd_en    = 1'b1;
          addr_nxt = next_addr;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      default: begin
        addr_nxt  = '0;
        state_nxt = B_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_INIT;
      addr_r      <= '0;
      epoch_r     <= EPOCH_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      epoch_r <= epoch_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    if (load_req) begin
      req_r  <= q_item.req_type;
      key_r  <= q_item.ip_address;
      node_r <= q_item.node_index;
    end
    if (out_load) begin
      out_data_r <= out_res;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[addr_r] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= slot_mem[rd_addr];
    end
  end

`ifndef ASSERT_OFF
  a_no_read_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_INIT) |-> !rd_en)
    else $error("slot read during clear pass");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> slot_free)
    else $error("result overwrites pending transaction");

  a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != B_INIT) |-> (epoch_r != EPOCH_CLR))
    else $error("cleared epoch in use");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.found && out_data_r.table_full))
    else $error("found and table_full both set");

  a_probe_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == B_IDLE) && (state_nxt == B_PROBE)) |=> (cnt_r == '0))
    else $error("probe count not restarted");
`endif

endmodule

### rtl/core/ip_hash_linear_probe_table_core.sv
// ip_hash_linear_probe_table_core: top level of the IPv4 to node hash table.
// Depends on iphash_pkg, iphash_front, iphash_fifo and iphash_back.
//
//   channel  dir  handshake             payload
//   in_      in   in_valid / in_ready   iphash_pkg::in_item_t  (req, address, node)
//   out_     out  out_valid / out_ready iphash_pkg::out_item_t (found, node, full)
//
// Front end: per transaction, hash multiply and fold for power-of-two SLOTS, then the push;
//   otherwise also a slot modulo, 4 bits per cycle. It takes one request at a time.
// Probe engine: insert/lookup read slots one by one through one memory read
//   port; clear and unused codes need no slot read.
// After reset, and after every 255th clear, a clear pass that writes every slot holds in_ready low.
// A stalled output holds one result; the two-entry queue keeps the front end running until it fills.
module ip_hash_linear_probe_table_core #(
  parameter int SLOTS = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  iphash_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output iphash_pkg::out_item_t out_data
);
  import iphash_pkg::*;

  localparam int QW = $bits(in_item_t) + $clog2(SLOTS);

  back_status_t  status;
  logic          push_valid, push_ready;
  logic [QW-1:0] push_data;
  logic          pop_valid, pop_ready;
  logic [QW-1:0] pop_data;

  iphash_front #(
    .SLOTS(SLOTS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .status     (status),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  iphash_fifo #(
    .W     (QW),
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  iphash_back #(
    .SLOTS(SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
